// ----- rtl/core/lfu_pkg.sv -----
package lfu_pkg;

    localparam int KEY_BITS = 32;
    localparam int VAL_BITS = 31;
    localparam int CAP_BITS = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [KEY_BITS-1:0] lookup_key;
        logic [VAL_BITS-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic                hit;
        logic [VAL_BITS-1:0] read_value;
        logic                evicted;
        logic [KEY_BITS-1:0] evicted_key;
    } out_item_t;

endpackage

// ----- rtl/core/lfu_ram.sv -----
module lfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/lfu_cache_table.sv -----
// Channel   Direction  Handshake            Payload
// command   in         start high, busy low cmd (opcode, lookup_key, write_value)
// result    out        done, one cycle      result (hit, read_value, evicted, evicted_key)
// config    in         cfg_we               cfg_wdata (capacity_in_use)
//
// Busy stays high from accept until the state returns to idle; no new item is taken meanwhile.
// The item walks the key and value memories one entry per cycle through one compare unit.
// The result is strobed in the cycle after the table update; a new item may start then.
// Reset marks all entries invalid and sets the capacity to 16; no clearing pass is needed.
// The receiver cannot stall; done is high for exactly one cycle per item.
module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_item_t            cmd,
    output logic                done,
    output out_item_t           result,
    input  logic                cfg_we,
    input  logic [CAP_BITS-1:0] cfg_wdata
);

    localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_BITS = IDX_BITS;
    localparam int ENT_W     = $clog2(ENTRIES + 1);
    localparam int CW        = (ENT_W > CAP_BITS) ? ENT_W : CAP_BITS;

    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(ENTRIES - 1);
    localparam logic [CW-1:0]         ENT_CAP   = CW'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CAP_BITS-1:0]   capacity_reg;
    logic [CW-1:0]         fill_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [COUNT_BITS-1:0] count_reg [ENTRIES];
    logic [RANK_BITS-1:0]  rank_reg  [ENTRIES];
    in_item_t              req_reg;
    logic [IDX_BITS-1:0]   cmp_idx_reg;

    logic                  found_reg;
    logic [IDX_BITS-1:0]   found_idx_reg;
    logic [COUNT_BITS-1:0] found_cnt_reg;
    logic [RANK_BITS-1:0]  found_rank_reg;
    logic [VAL_BITS-1:0]   found_val_reg;
    logic                  free_reg;
    logic [IDX_BITS-1:0]   free_idx_reg;
    logic                  vic_reg;
    logic [IDX_BITS-1:0]   vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [RANK_BITS-1:0]  vic_rank_reg;
    logic [KEY_BITS-1:0]   vic_key_reg;

    logic                  done_reg;
    out_item_t             result_reg;

    logic [KEY_BITS-1:0]   key_q;
    logic [VAL_BITS-1:0]   val_q;
    logic [IDX_BITS-1:0]   raddr;
    logic                  cur_valid;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [RANK_BITS-1:0]  cur_rank;
    logic                  cur_match;
    logic                  cur_better;

    logic [CW-1:0]         cap_ext;
    logic [CW-1:0]         cap_eff;
    logic                  is_put;
    logic                  do_touch;
    logic                  do_evict;
    logic                  do_fill;
    logic                  do_insert;
    logic [IDX_BITS-1:0]   tgt_idx;
    logic [RANK_BITS-1:0]  tgt_rank;
    logic [COUNT_BITS-1:0] touch_cnt;
    logic                  key_we;
    logic                  val_we;
    logic                  accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign raddr = (state_reg == ST_SCAN && cmp_idx_reg != LAST_IDX)
                   ? cmp_idx_reg + IDX_BITS'(1) : '0;

    assign cur_valid  = valid_reg[cmp_idx_reg];
    assign cur_cnt    = count_reg[cmp_idx_reg];
    assign cur_rank   = rank_reg[cmp_idx_reg];
    assign cur_match  = cur_valid && (key_q == req_reg.lookup_key);
    assign cur_better = cur_valid && (!vic_reg || (cur_cnt < vic_cnt_reg) ||
                        ((cur_cnt == vic_cnt_reg) && (cur_rank > vic_rank_reg)));

    assign cap_ext   = CW'(capacity_reg);
    assign cap_eff   = (cap_ext > ENT_CAP) ? ENT_CAP : cap_ext;
    assign is_put    = (req_reg.opcode == OP_PUT);
    assign do_touch  = found_reg && (!is_put || cap_eff != '0);
    assign do_evict  = is_put && (cap_eff != '0) && !found_reg && (fill_reg >= cap_eff) && vic_reg;
    assign do_fill   = is_put && (cap_eff != '0) && !found_reg && (fill_reg < cap_eff) && free_reg;
    assign do_insert = do_evict || do_fill;
    assign tgt_idx   = do_touch ? found_idx_reg : (do_evict ? vic_idx_reg : free_idx_reg);
    assign tgt_rank  = do_touch ? found_rank_reg : vic_rank_reg;
    assign touch_cnt = (found_cnt_reg == COUNT_MAX) ? found_cnt_reg
                       : found_cnt_reg + COUNT_BITS'(1);

    assign key_we = (state_reg == ST_UPDATE) && do_insert;
    assign val_we = (state_reg == ST_UPDATE) && (do_insert || (do_touch && is_put));

    lfu_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (tgt_idx),
        .wdata (req_reg.lookup_key),
        .raddr (raddr),
        .rdata (key_q)
    );

    lfu_ram #(
        .WIDTH (VAL_BITS),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (tgt_idx),
        .wdata (req_reg.write_value),
        .raddr (raddr),
        .rdata (val_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cmp_idx_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            fill_reg     <= '0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            cmp_idx_reg  <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            vic_reg      <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                count_reg[i] <= '0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_UPDATE);
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                cmp_idx_reg <= '0;
                found_reg   <= 1'b0;
                free_reg    <= 1'b0;
                vic_reg     <= 1'b0;
            end
            if (state_reg == ST_SCAN)
            begin
                cmp_idx_reg <= raddr;
                if (cur_match && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!cur_valid && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (cur_better)
                begin
                    vic_reg <= 1'b1;
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                if (do_fill)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_BITS'(i) == tgt_idx && (do_touch || do_insert))
                    begin
                        rank_reg[i] <= '0;
                        if (do_touch)
                        begin
                            count_reg[i] <= touch_cnt;
                        end
                        else
                        begin
                            count_reg[i] <= COUNT_BITS'(1);
                            valid_reg[i] <= 1'b1;
                        end
                    end
                    else if (valid_reg[i])
                    begin
                        if (do_fill || ((do_touch || do_evict) && rank_reg[i] < tgt_rank))
                        begin
                            rank_reg[i] <= rank_reg[i] + RANK_BITS'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= cmd;
        end
        if (state_reg == ST_SCAN)
        begin
            if (cur_match && !found_reg)
            begin
                found_idx_reg  <= cmp_idx_reg;
                found_cnt_reg  <= cur_cnt;
                found_rank_reg <= cur_rank;
                found_val_reg  <= val_q;
            end
            if (!cur_valid && !free_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (cur_better)
            begin
                vic_idx_reg  <= cmp_idx_reg;
                vic_cnt_reg  <= cur_cnt;
                vic_rank_reg <= cur_rank;
                vic_key_reg  <= key_q;
            end
        end
        if (state_reg == ST_UPDATE)
        begin
            result_reg.hit         <= found_reg;
            result_reg.read_value  <= (!is_put && found_reg) ? found_val_reg : '0;
            result_reg.evicted     <= do_evict;
            result_reg.evicted_key <= do_evict ? vic_key_reg : '0;
        end
    end

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without a table update");

    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(fill_reg))
        else $error("fill count disagrees with valid entries");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.evicted) |-> !result_reg.hit)
        else $error("eviction reported on a hit");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOAD))
        else $error("accepted item did not start a scan");

endmodule
